[rtl/cmil_pkg.sv]
// ----------------------------------------------------------------------------
// cmil_pkg: shared types and constants for the colormap lookup
// Payload structs, operation codes and parameter defaults used by the
// top level, the port checker and the testbench.
// ----------------------------------------------------------------------------
package cmil_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_STOPS    = 16;
    localparam int NUM_CHANNELS = 4;
    localparam int VALUE_BITS   = 16;

    // Fixed payload geometry
    localparam int FIELD_BITS   = 16;
    localparam int RESULT_CH    = 4;
    localparam int CFG_BITS     = 5;

    localparam logic [CFG_BITS-1:0] ENTRIES_RESET = 5'd1;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  stop_slot;
        logic [15:0] stop_key;
        logic [15:0] stop_ch0;
        logic [15:0] stop_ch1;
        logic [15:0] stop_ch2;
        logic [15:0] stop_ch3;
        logic [15:0] sample_value;
    } t_item;

    typedef struct packed {
        logic [3:0]  segment_index;
        logic [15:0] color_ch0;
        logic [15:0] color_ch1;
        logic [15:0] color_ch2;
        logic [15:0] color_ch3;
    } t_result;

endpackage

[rtl/cmil_ram.sv]
// ----------------------------------------------------------------------------
// cmil_ram: generic single-port-write, single-port-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module cmil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cmil_div.sv]
// ----------------------------------------------------------------------------
// cmil_div: serial restoring divider
// Divides a 2*VB-bit dividend by a VB-bit divisor, one quotient bit per
// cycle. The caller guarantees the quotient fits in VB bits.
// ----------------------------------------------------------------------------
module cmil_div #(
    parameter int VB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*VB-1:0] i_dividend,
    input  logic [VB-1:0]   i_divisor,
    output logic            o_done,
    output logic [VB-1:0]   o_quot
);

    localparam int CW = $clog2(VB + 1);

    logic [VB-1:0] r_rem;
    logic [VB-1:0] r_low;
    logic [VB-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VB:0]   trial;
    logic [VB:0]   diff;
    logic          qbit;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_low[VB-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
    end

    // Control: count the steps, flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*VB-1:VB];
            r_low <= i_dividend[VB-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[VB-1:0] : trial[VB-1:0];
            r_low <= {r_low[VB-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

[rtl/colormap_interpolating_lookup_top.sv]
// ----------------------------------------------------------------------------
// colormap_interpolating_lookup_top: interpolating colormap table
// Stores colormap stops and maps sample values to interpolated colors.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high
//   and busy low. A write item (op = OP_WRITE) stores one stop in the same
//   cycle and produces no result; busy stays low, so writes can stream one
//   per cycle. A lookup item raises busy until its result is loaded.
//   Result channel: o_result_valid is high for exactly one cycle with the
//   result on o_result; the receiver cannot stall and must take it then.
//   Configuration: i_cfg_we writes entries_in_use from i_cfg_wdata; write
//   it only while the block is idle.
//   A lookup at or below the first key, or at or above the last key,
//   returns that stop's color; otherwise a binary search brackets the
//   value and each channel is blended in the shared multiplier and
//   divided by the serial divider, one quotient bit per cycle shared by
//   all channels. Busy drops the cycle the result appears, so the
//   next item can transfer while the result is shown.
//   Reset: entries_in_use returns to 1 and the sequencer goes idle; the
//   stop table is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module colormap_interpolating_lookup_top #(
    parameter int MAX_STOPS    = cmil_pkg::MAX_STOPS,
    parameter int NUM_CHANNELS = cmil_pkg::NUM_CHANNELS,
    parameter int VALUE_BITS   = cmil_pkg::VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cmil_pkg::t_item                 i_item,
    input  logic                            i_cfg_we,
    input  logic [cmil_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    output logic                            o_result_valid,
    output cmil_pkg::t_result               o_result
);

    localparam int VB  = VALUE_BITS;
    localparam int NC  = NUM_CHANNELS;
    localparam int AW  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CHW = (NC > 1) ? $clog2(NC) : 1;
    localparam int RC  = cmil_pkg::RESULT_CH;
    localparam int FB  = cmil_pkg::FIELD_BITS;

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_K0       = 16'b0000_0000_0000_0010,
        S_KN       = 16'b0000_0000_0000_0100,
        S_CHKN     = 16'b0000_0000_0000_1000,
        S_SRCH_RD  = 16'b0000_0000_0001_0000,
        S_SRCH_CMP = 16'b0000_0000_0010_0000,
        S_CRD_LO   = 16'b0000_0000_0100_0000,
        S_CRD_HI   = 16'b0000_0000_1000_0000,
        S_PREP     = 16'b0000_0001_0000_0000,
        S_MUL_A    = 16'b0000_0010_0000_0000,
        S_MUL_B    = 16'b0000_0100_0000_0000,
        S_SUM      = 16'b0000_1000_0000_0000,
        S_DIV_GO   = 16'b0001_0000_0000_0000,
        S_DIV_WAIT = 16'b0010_0000_0000_0000,
        S_CRD_EDGE = 16'b0100_0000_0000_0000,
        S_EDGE_OUT = 16'b1000_0000_0000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [cmil_pkg::CFG_BITS-1:0] r_entries;
    logic [VB-1:0]              r_v;
    logic [AW-1:0]              r_lo, r_hi;
    logic [VB-1:0]              r_klo, r_khi;
    logic [VB*NC-1:0]           r_clo, r_chi;
    logic [VB-1:0]              r_dlo, r_dhi, r_range;
    logic [2*VB-1:0]            r_prod, r_num;
    logic [CHW-1:0]             r_ch;
    logic [FB-1:0]              r_color [RC];
    logic [AW-1:0]              r_seg;
    logic                       r_valid;

    logic                       accept, wr_en;
    logic [AW-1:0]              last_idx, mid;
    logic [AW-1:0]              key_raddr, col_raddr;
    logic [VB-1:0]              key_rdata, key_wdata;
    logic [VB*NC-1:0]           col_rdata, col_wdata;
    logic [VB*RC-1:0]           col_pad;
    logic [RC-1:0][FB-1:0]      ch_in;
    logic [AW-1:0]              new_lo, new_hi;
    logic                       go_right;
    logic [VB-1:0]              m_a, m_b;
    logic [2*VB-1:0]            m_p;
    logic                       div_start, div_done;
    logic [VB-1:0]              div_q;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_item.op == cmil_pkg::OP_WRITE)
                    && (32'(i_item.stop_slot) < MAX_STOPS);

    // Clamp the entry count into 1..MAX_STOPS and take the last index
    always_comb begin
        if (r_entries == '0) begin
            last_idx = '0;
        end else if (32'(r_entries) > MAX_STOPS) begin
            last_idx = AW'(MAX_STOPS - 1);
        end else begin
            last_idx = AW'(r_entries - cmil_pkg::CFG_BITS'(1));
        end
    end

    // Pack the write item into table words
    always_comb begin
        ch_in     = {i_item.stop_ch3, i_item.stop_ch2, i_item.stop_ch1, i_item.stop_ch0};
        key_wdata = VB'(i_item.stop_key);
        col_wdata = '0;
        for (int c = 0; c < NC; c++) begin
            col_wdata[c*VB +: VB] = VB'(ch_in[c]);
        end
    end

    // Binary search step
    always_comb begin
        mid      = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        go_right = (key_rdata <= r_v);
        new_lo   = go_right ? mid : r_lo;
        new_hi   = go_right ? r_hi : mid;
    end

    // Read address selection per state
    always_comb begin
        key_raddr = '0;
        col_raddr = '0;
        case (r_state)
            S_KN:       key_raddr = last_idx;
            S_SRCH_RD:  key_raddr = mid;
            S_CRD_LO:   col_raddr = r_lo;
            S_CRD_HI:   col_raddr = r_hi;
            S_CRD_EDGE: col_raddr = r_lo;
            default: begin
                key_raddr = '0;
                col_raddr = '0;
            end
        endcase
    end

    cmil_ram #(.WIDTH(VB), .DEPTH(MAX_STOPS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_item.stop_slot)),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    cmil_ram #(.WIDTH(VB*NC), .DEPTH(MAX_STOPS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_item.stop_slot)),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    assign col_pad = (VB*RC)'(col_rdata);

    // Shared multiplier: low stop weight first, then high stop weight
    always_comb begin
        m_a = (r_state == S_MUL_B) ? r_chi[r_ch*VB +: VB] : r_clo[r_ch*VB +: VB];
        m_b = (r_state == S_MUL_B) ? r_dlo : r_dhi;
        m_p = (2*VB)'(m_a) * (2*VB)'(m_b);
    end

    assign div_start = (r_state == S_DIV_GO);

    cmil_div #(.VB(VB)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (r_range),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_item.op == cmil_pkg::OP_LOOKUP)) n_state = S_K0;
            end
            S_K0:       n_state = S_KN;
            S_KN:       n_state = (r_v <= key_rdata) ? S_CRD_EDGE : S_CHKN;
            S_CHKN: begin
                if (key_rdata <= r_v) begin
                    n_state = S_CRD_EDGE;
                end else if (last_idx > AW'(1)) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_CRD_LO;
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (({1'b0, new_hi} - {1'b0, new_lo}) > (AW+1)'(1)) begin
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_CRD_LO;
                end
            end
            S_CRD_LO:   n_state = S_CRD_HI;
            S_CRD_HI:   n_state = S_PREP;
            S_PREP:     n_state = S_MUL_A;
            S_MUL_A:    n_state = S_MUL_B;
            S_MUL_B:    n_state = S_SUM;
            S_SUM:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_ch == CHW'(NC - 1)) ? S_IDLE : S_MUL_A;
                end
            end
            S_CRD_EDGE: n_state = S_EDGE_OUT;
            S_EDGE_OUT: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_entries <= cmil_pkg::ENTRIES_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            r_valid <= (r_state == S_EDGE_OUT)
                       || ((r_state == S_DIV_WAIT) && div_done && (r_ch == CHW'(NC - 1)));
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_v <= VB'(i_item.sample_value);
            end
            S_KN: begin
                // hold the first key; an edge hit selects stop 0
                r_klo <= key_rdata;
                r_lo  <= '0;
            end
            S_CHKN: begin
                r_khi <= key_rdata;
                r_lo  <= (key_rdata <= r_v) ? last_idx : '0;
                r_hi  <= last_idx;
            end
            S_SRCH_CMP: begin
                r_lo <= new_lo;
                r_hi <= new_hi;
                if (go_right) begin
                    r_klo <= key_rdata;
                end else begin
                    r_khi <= key_rdata;
                end
            end
            S_CRD_HI: begin
                r_clo <= col_rdata;
            end
            S_PREP: begin
                r_chi   <= col_rdata;
                r_dhi   <= r_khi - r_v;
                r_dlo   <= r_v - r_klo;
                r_range <= r_khi - r_klo;
                r_ch    <= '0;
                r_seg   <= r_lo;
                for (int c = 0; c < RC; c++) begin
                    r_color[c] <= '0;
                end
            end
            S_MUL_A: begin
                r_prod <= m_p;
                r_num  <= (2*VB)'(r_range >> 1);
            end
            S_MUL_B: begin
                r_prod <= m_p;
                r_num  <= r_num + r_prod;
            end
            S_SUM: begin
                r_num <= r_num + r_prod;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    for (int c = 0; c < RC; c++) begin
                        if ((c < NC) && (r_ch == CHW'(c))) begin
                            r_color[c] <= FB'(div_q);
                        end
                    end
                    r_ch <= r_ch + CHW'(1);
                end
            end
            S_EDGE_OUT: begin
                r_seg <= r_lo;
                for (int c = 0; c < RC; c++) begin
                    r_color[c] <= (c < NC) ? FB'(col_pad[c*VB +: VB]) : '0;
                end
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

    // Drive the result
    assign o_result_valid          = r_valid;
    assign o_result.segment_index  = 4'(r_seg);
    assign o_result.color_ch0      = r_color[0];
    assign o_result.color_ch1      = r_color[1];
    assign o_result.color_ch2      = r_color[2];
    assign o_result.color_ch3      = r_color[3];

endmodule

[rtl/cmil_checker.sv]
// ----------------------------------------------------------------------------
// cmil_checker: port-level checks for the colormap lookup
// Watches the command, result and reset behavior seen at the top level.
// ----------------------------------------------------------------------------
module cmil_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input cmil_pkg::t_item               i_item,
    input logic                          o_result_valid,
    input cmil_pkg::t_result             o_result
);

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("block not idle after reset");

    // A write transfer never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == cmil_pkg::OP_WRITE) |=> !o_result_valid)
        else $error("result after a write transfer");

    // A lookup transfer takes the block busy
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == cmil_pkg::OP_LOOKUP) |=> busy)
        else $error("lookup transfer did not raise busy");

    // A result is a single-cycle strobe and arrives with the block free
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && !$past(o_result_valid)))
        else $error("result strobe malformed");

endmodule

bind colormap_interpolating_lookup_top cmil_checker u_cmil_checker (.*);

[tb/sv/cmil_lookup_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmil_lookup_monitor: port monitor and color predictor for the colormap lookup
// Watches the command, configuration and result ports of the block. Keeps its
// own copy of the stop table and the entry count, predicts the color of every
// lookup that transfers and compares each result field against the oldest
// prediction. Hands the failure count and the number of open lookups upward.
// ----------------------------------------------------------------------------
module cmil_lookup_monitor
    import cmil_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_item               i_item,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    input  logic                i_result_valid,
    input  t_result             i_result,
    output int                  o_outstanding,
    output int                  o_fail_count,
    output int                  o_results_checked
);

    // Shadow stop table and entry count
    logic [15:0]         key_mem   [MAX_STOPS];
    logic [15:0]         color_mem [MAX_STOPS][RESULT_CH];
    logic [CFG_BITS-1:0] entries_cfg = ENTRIES_RESET;

    t_result color_expect_q[$];
    t_result want;
    int      fail_total    = 0;
    int      checked_total = 0;

    assign o_fail_count      = fail_total;
    assign o_results_checked = checked_total;

    // Print one line per mismatch and count it
    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_v);
        if (got !== exp_v) begin
            flag_error($sformatf("%s got %h, predicted %h", name, got, exp_v));
        end
    endtask

    // Map one sample value to the color the block must return
    function automatic t_result predict_color(input logic [15:0] sample_v);
        t_result         r;
        int unsigned     n;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        bit              hit_end;
        longint unsigned v;
        longint unsigned k0;
        longint unsigned k1;
        longint unsigned span;
        longint unsigned num;
        longint unsigned c_lo;
        longint unsigned c_hi;
        logic [15:0]     ch [RESULT_CH];

        // Zero acts as one stop, anything above the table saturates
        if (entries_cfg == 0) n = 1;
        else if (entries_cfg > MAX_STOPS) n = MAX_STOPS;
        else n = entries_cfg;

        v       = sample_v;
        lo      = 0;
        hi      = 0;
        hit_end = 1'b1;
        k0      = 0;
        k1      = 0;
        span    = 1;
        if (sample_v <= key_mem[0]) begin
            lo = 0;
        end else if (key_mem[n-1] <= sample_v) begin
            lo = n - 1;
        end else begin
            // Narrow the bracket, keeping key[lo] <= v < key[hi]
            hit_end = 1'b0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (key_mem[mid] <= sample_v) lo = mid;
                else hi = mid;
            end
            k0   = key_mem[lo];
            k1   = key_mem[lo+1];
            span = k1 - k0;
        end

        // Blend the two stops, rounding to nearest with ties up
        for (int c = 0; c < RESULT_CH; c++) begin
            if (hit_end) begin
                ch[c] = color_mem[lo][c];
            end else begin
                c_lo  = color_mem[lo][c];
                c_hi  = color_mem[lo+1][c];
                num   = c_lo * (k1 - v) + c_hi * (v - k0) + span / 2;
                ch[c] = 16'(num / span);
            end
        end

        r.segment_index = 4'(lo);
        r.color_ch0     = ch[0];
        r.color_ch1     = ch[1];
        r.color_ch2     = ch[2];
        r.color_ch3     = ch[3];
        return r;
    endfunction

    // Track register writes, command transfers and result strobes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries_cfg = ENTRIES_RESET;
            color_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                entries_cfg = i_cfg_wdata;
            end

            // Compare the result against the oldest open lookup
            if (i_result_valid) begin
                if (color_expect_q.size() == 0) begin
                    flag_error("result strobe with no lookup outstanding");
                end else begin
                    want = color_expect_q.pop_front();
                    check_field("segment_index", 16'(i_result.segment_index),
                                16'(want.segment_index));
                    check_field("color_ch0", i_result.color_ch0, want.color_ch0);
                    check_field("color_ch1", i_result.color_ch1, want.color_ch1);
                    check_field("color_ch2", i_result.color_ch2, want.color_ch2);
                    check_field("color_ch3", i_result.color_ch3, want.color_ch3);
                    checked_total++;
                end
            end

            // Apply a write or predict a lookup on each command transfer
            if (i_start && !i_busy) begin
                if (i_item.op == OP_WRITE) begin
                    key_mem[i_item.stop_slot]      = i_item.stop_key;
                    color_mem[i_item.stop_slot][0] = i_item.stop_ch0;
                    color_mem[i_item.stop_slot][1] = i_item.stop_ch1;
                    color_mem[i_item.stop_slot][2] = i_item.stop_ch2;
                    color_mem[i_item.stop_slot][3] = i_item.stop_ch3;
                end else begin
                    color_expect_q = {color_expect_q, predict_color(i_item.sample_value)};
                end
            end
        end
        o_outstanding <= color_expect_q.size();
    end

endmodule

[tb/sv/tb_colormap_interpolating_lookup_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colormap_interpolating_lookup_top: regression for the colormap lookup
// Loads stop tables (ascending, narrow with repeated keys, and out of order),
// steps the entry count through its extremes and streams lookups with random
// gaps. A separate monitor predicts and checks every result; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_colormap_interpolating_lookup_top;
    import cmil_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;
    localparam int SETTLE_WAIT  = 8;
    localparam int DRAIN_CYCLES = 120;
    localparam int KEY_STEP     = 4369;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    t_item               cmd;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_wdata;
    logic                result_valid;
    t_result             result;

    int outstanding;
    int fail_count;
    int results_checked;
    int cycle_count   = 0;
    int items_sent    = 0;
    int writes_sent   = 0;
    int lookups_sent  = 0;
    int settings_used = 0;
    int active_n      = 1;
    int phase;

    logic [15:0] shadow_keys [MAX_STOPS];

    colormap_interpolating_lookup_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (cmd),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    cmil_lookup_monitor u_monitor (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_item            (cmd),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_result_valid    (result_valid),
        .i_result          (result),
        .o_outstanding     (outstanding),
        .o_fail_count      (fail_count),
        .o_results_checked (results_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d lookups still open",
                     cycle_count, outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_item random_item();
        t_item it;
        it.op           = t_op'($urandom_range(1));
        it.stop_slot    = 4'($urandom);
        it.stop_key     = 16'($urandom);
        it.stop_ch0     = 16'($urandom);
        it.stop_ch1     = 16'($urandom);
        it.stop_ch2     = 16'($urandom);
        it.stop_ch3     = 16'($urandom);
        it.sample_value = 16'($urandom);
        return it;
    endfunction

    // Present one command, with an occasional gap, and hold it until transfer
    task automatic issue_item(input t_item it);
        if ((items_sent < QUIET_FIRST || items_sent >= QUIET_LAST)
                && $urandom_range(99) < 12) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(5)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= it;
        do @(posedge clk); while (busy);
        items_sent++;
        if (it.op == OP_WRITE) begin
            writes_sent++;
            shadow_keys[it.stop_slot] = it.stop_key;
        end else begin
            lookups_sent++;
        end
    endtask

    task automatic write_stop(input logic [3:0] slot, input logic [15:0] key,
                              input logic [63:0] colors);
        t_item it;
        it           = random_item();
        it.op        = OP_WRITE;
        it.stop_slot = slot;
        it.stop_key  = key;
        {it.stop_ch0, it.stop_ch1, it.stop_ch2, it.stop_ch3} = colors;
        issue_item(it);
    endtask

    task automatic look_up(input logic [15:0] value);
        t_item it;
        it              = random_item();
        it.op           = OP_LOOKUP;
        it.sample_value = value;
        issue_item(it);
    endtask

    // Drain open lookups, then write the entry count while idle
    task automatic set_entries(input logic [CFG_BITS-1:0] n);
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (n == 0) active_n = 1;
        else if (n > MAX_STOPS) active_n = MAX_STOPS;
        else active_n = n;
        settings_used++;
    endtask

    // Rewrite every slot: mostly sorted keys, sometimes packed close, rarely scrambled
    task automatic load_table();
        int          mode;
        int          width;
        int          base;
        logic [15:0] kq[$];
        mode = $urandom_range(99);
        if (mode < 85) begin
            width = (mode < 65) ? 65535 : $urandom_range(300, 8);
            base  = $urandom_range(65535 - width);
            repeat (MAX_STOPS) kq = {kq, 16'(base + $urandom_range(width))};
            kq.sort();
            if ($urandom_range(3) == 0) begin
                kq[0]           = 16'h0000;
                kq[MAX_STOPS-1] = 16'hFFFF;
            end
        end else begin
            repeat (MAX_STOPS) kq = {kq, 16'($urandom)};
        end
        for (int s = 0; s < MAX_STOPS; s++) begin
            write_stop(4'(s), kq[s], {$urandom, $urandom});
        end
    endtask

    // Mostly in-range samples, some exact keys, some anywhere, a few stray writes
    task automatic lookup_burst();
        int          pick;
        int          slot;
        logic [15:0] lo_k;
        logic [15:0] hi_k;
        repeat ($urandom_range(80, 40)) begin
            pick = $urandom_range(99);
            lo_k = shadow_keys[0];
            hi_k = shadow_keys[active_n-1];
            if (pick < 8) begin
                slot = $urandom_range(MAX_STOPS - 1);
                write_stop(4'(slot), (pick < 2) ? 16'($urandom) : shadow_keys[slot],
                           {$urandom, $urandom});
            end else if (pick < 14) begin
                look_up(shadow_keys[$urandom_range(active_n - 1)]);
            end else if (pick < 24 || lo_k >= hi_k) begin
                look_up(16'($urandom));
            end else begin
                look_up(16'($urandom_range(hi_k, lo_k)));
            end
        end
    endtask

    function automatic logic [CFG_BITS-1:0] pick_entries(input int ph);
        case (ph % 8)
            0:       return CFG_BITS'(MAX_STOPS);
            1:       return 5'd2;
            2:       return 5'd1;
            3:       return 5'd31;
            4:       return 5'd0;
            5:       return CFG_BITS'($urandom_range(MAX_STOPS - 1, 3));
            6:       return CFG_BITS'($urandom_range(30, MAX_STOPS + 1));
            default: return CFG_BITS'($urandom_range(MAX_STOPS, 1));
        endcase
    endfunction

    initial begin
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Evenly spaced keys over the full range; first stop all zero, last all ones
        for (int s = 0; s < MAX_STOPS; s++) begin
            if (s == 0) write_stop(4'(s), 16'h0000, 64'h0);
            else if (s == MAX_STOPS - 1) write_stop(4'(s), 16'hFFFF, '1);
            else write_stop(4'(s), 16'(s * KEY_STEP),
                            {16'(s * KEY_STEP), 16'(65535 - s * KEY_STEP),
                             (s % 2) ? 16'hFFFF : 16'h0000, 16'hA5A5 ^ 16'(s * 257)});
        end

        // Single stop after reset
        look_up(16'h0000);
        look_up(16'hFFFF);

        // Full table: both ends, an exact key, just below it, near a midpoint
        set_entries(CFG_BITS'(MAX_STOPS));
        look_up(16'h0000);
        look_up(16'hFFFF);
        look_up(16'(5 * KEY_STEP));
        look_up(16'(5 * KEY_STEP - 1));
        look_up(16'(KEY_STEP / 2));
        look_up(16'h8000);

        // Zero count acts as one, oversize count saturates
        set_entries(5'd0);
        look_up(16'd30000);
        set_entries(5'd31);
        look_up(16'hFFFE);

        // Random phases until the item budget is spent
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            set_entries(pick_entries(phase));
            load_table();
            lookup_burst();
            phase++;
        end

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d stop writes and %0d lookups over %0d entry-count settings",
                 writes_sent, lookups_sent, settings_used);
        $display("Checked %0d results, %0d mismatches, %0d left open",
                 results_checked, fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cmil_pkg.sv
rtl/cmil_ram.sv
rtl/cmil_div.sv
rtl/colormap_interpolating_lookup_top.sv
rtl/cmil_checker.sv
tb/sv/cmil_lookup_monitor.sv
tb/sv/tb_colormap_interpolating_lookup_top.sv
